>>> hw/rtl/necd_pkg.sv
// Shared constants and types for the NEC IR command decoder.
// No dependencies; imported by necd_core and nec_ir_command_decoder_top.
package necd_pkg;

  localparam int TICK_W    = 24;
  localparam int EDGE_W    = 6;
  localparam int CMD_W     = 8;
  localparam int LED_W     = 3;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

  localparam logic [EDGE_W:0] FIRST_COMMAND_EDGE = 7'd17;
  localparam logic [EDGE_W:0] LAST_COMMAND_EDGE  = FIRST_COMMAND_EDGE + 7'd7;

  localparam logic [TICK_W-1:0] FRAME_TIMEOUT_RST = 24'd80000;
  localparam logic [TICK_W-1:0] ONE_BIT_MIN_RST   = 24'd2000;
  localparam logic [TICK_W-1:0] ONE_BIT_MAX_RST   = 24'd2300;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_MAX   = 2'd2;

  localparam logic [CMD_W-1:0] CODE_LEDS_OFF  = 8'd69;
  localparam logic [CMD_W-1:0] CODE_LED_PIN1  = 8'd12;
  localparam logic [CMD_W-1:0] CODE_LED_PIN2  = 8'd24;
  localparam logic [CMD_W-1:0] CODE_LED_PIN3  = 8'd94;
  localparam logic [CMD_W-1:0] CODE_MODE_STEP = 8'd70;

  localparam logic [LED_W-1:0] LEDS_OFF  = 3'd0;
  localparam logic [LED_W-1:0] LEDS_PIN1 = 3'd1;
  localparam logic [LED_W-1:0] LEDS_PIN2 = 3'd2;
  localparam logic [LED_W-1:0] LEDS_PIN3 = 3'd4;
  localparam logic [LED_W-1:0] LEDS_M1   = 3'd6;
  localparam logic [LED_W-1:0] LEDS_M2   = 3'd5;
  localparam logic [LED_W-1:0] LEDS_M3   = 3'd3;
  localparam logic [LED_W-1:0] LEDS_M4   = 3'd7;

  localparam logic [MODE_W-1:0] MODE_1 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_2 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_3 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_4 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_5 = 3'd5;

  typedef struct packed {
    logic             hit;
    logic [CMD_W-1:0] command;
    logic [LED_W-1:0] leds;
  } result_t;

endpackage

>>> hw/rtl/necd_core.sv
// Frame state, edge interval measure and LED command logic of the decoder.
// Depends on necd_pkg.
module necd_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [necd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [necd_pkg::TICK_W-1:0]     cfg_data,
  input  logic                            step,
  input  logic                            edge_req,
  output necd_pkg::result_t               res
);
  import necd_pkg::*;

  logic [TICK_W-1:0] frame_timeout;
  logic [TICK_W-1:0] one_bit_min;
  logic [TICK_W-1:0] one_bit_max;

  logic              frame_started, frame_started_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [EDGE_W-1:0] edge_index, edge_index_next;
  logic [CMD_W-1:0]  command_bits, command_bits_next;
  logic [LED_W-1:0]  led_state, led_state_next;
  logic [MODE_W-1:0] mode_step, mode_step_next;

  logic [TICK_W-1:0] tick_inc;
  logic              in_cmd_range;
  logic [2:0]        bit_pos;
  logic              is_one;
  logic [LED_W-1:0]  cmd_leds;
  logic [MODE_W-1:0] cmd_mode;

  assign tick_inc     = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
  assign in_cmd_range = ({1'b0, edge_index} >= FIRST_COMMAND_EDGE) &&
                        ({1'b0, edge_index} <= LAST_COMMAND_EDGE);
  assign bit_pos      = 3'({1'b0, edge_index} - FIRST_COMMAND_EDGE);
  assign is_one       = (tick_inc >= one_bit_min) && (tick_inc <= one_bit_max);

  always_comb begin
    cmd_leds = led_state;
    cmd_mode = mode_step;
    case (command_bits)
      CODE_LEDS_OFF: cmd_leds = LEDS_OFF;
      CODE_LED_PIN1: cmd_leds = LEDS_PIN1;
      CODE_LED_PIN2: cmd_leds = LEDS_PIN2;
      CODE_LED_PIN3: cmd_leds = LEDS_PIN3;
      CODE_MODE_STEP: begin
        case (mode_step)
          MODE_1: begin
            cmd_leds = LEDS_M1;
            cmd_mode = MODE_2;
          end
          MODE_2: begin
            cmd_leds = LEDS_M2;
            cmd_mode = MODE_3;
          end
          MODE_3: begin
            cmd_leds = LEDS_M3;
            cmd_mode = MODE_4;
          end
          MODE_4: begin
            cmd_leds = LEDS_M4;
            cmd_mode = MODE_5;
          end
          default: cmd_mode = MODE_1;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    frame_started_next = frame_started;
    tick_count_next    = tick_count;
    edge_index_next    = edge_index;
    command_bits_next  = command_bits;
    led_state_next     = led_state;
    mode_step_next     = mode_step;
    res.hit            = 1'b0;
    res.command        = command_bits;
    res.leds           = cmd_leds;
    if (!frame_started) begin
      if (edge_req) begin
        frame_started_next = 1'b1;
        tick_count_next    = '0;
      end
    end else if (edge_req) begin
      if (in_cmd_range) begin
        command_bits_next[bit_pos] = is_one;
      end
      if (edge_index != EDGE_MAX) begin
        edge_index_next = edge_index + 1'b1;
      end
      tick_count_next = '0;
    end else if (tick_inc >= frame_timeout) begin
      res.hit            = 1'b1;
      led_state_next     = cmd_leds;
      mode_step_next     = cmd_mode;
      frame_started_next = 1'b0;
      edge_index_next    = '0;
      tick_count_next    = '0;
    end else begin
      tick_count_next = tick_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_timeout <= FRAME_TIMEOUT_RST;
      one_bit_min   <= ONE_BIT_MIN_RST;
      one_bit_max   <= ONE_BIT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_TIMEOUT: frame_timeout <= cfg_data;
        REG_ONE_BIT_MIN:   one_bit_min   <= cfg_data;
        REG_ONE_BIT_MAX:   one_bit_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_started <= 1'b0;
      tick_count    <= '0;
      edge_index    <= '0;
      command_bits  <= '0;
      led_state     <= '0;
      mode_step     <= MODE_1;
    end else if (step) begin
      frame_started <= frame_started_next;
      tick_count    <= tick_count_next;
      edge_index    <= edge_index_next;
      command_bits  <= command_bits_next;
      led_state     <= led_state_next;
      mode_step     <= mode_step_next;
    end
  end

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode_step != '0 && mode_step <= MODE_5)
    else $error("mode step out of cycle");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && res.hit |=> !frame_started && edge_index == '0 && tick_count == '0)
    else $error("frame end did not clear frame state");
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !frame_started |-> edge_index == '0)
    else $error("edge index set outside a frame");

endmodule

>>> hw/rtl/nec_ir_command_decoder_top.sv
// Top level of the NEC IR command decoder: input beat register, core, result register.
// Depends on necd_pkg and necd_core.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[0] edge_req
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] command, [10:8] leds
//  cfg       in   cfg_we (no wait)              cfg_index, cfg_data[23:0]
//
// One tick beat per cycle sustained while m_axis is not stalled. A registered input beat
// steps the core when the output has room; that step loads a frame-end result to the output.
// rst is synchronous; it clears frame state, loads register reset values, empties stages.
// A stalled result holds the output register; the input register takes one more beat,
// then holds it and drops s_axis_tready until the result beat is taken.
module nec_ir_command_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] edge_req, [7:1] zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [7:0] command, [10:8] leds
  input  logic                            cfg_we,
  input  logic [necd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [necd_pkg::TICK_W-1:0]     cfg_data
);
  import necd_pkg::*;

  logic             in_valid;
  logic             in_edge;
  logic             out_valid;
  logic [CMD_W-1:0] out_command;
  logic [LED_W-1:0] out_leds;
  logic             out_room;
  logic             fire;
  result_t          res;

  assign out_room      = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_room;
  assign s_axis_tready = !in_valid || fire;

  necd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (fire),
    .edge_req  (in_edge),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_edge <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= fire && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.hit) begin
      out_command <= res.command;
      out_leds    <= res.leds;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_leds, out_command};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !fire)
    else $error("result register overwritten while stalled");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && out_valid && !m_axis_tready)
    else $error("input stalled without a full output");
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    fire && res.hit |=> out_valid)
    else $error("frame-end result lost");

endmodule
